[rtl/bma_pkg.sv]
// Shared types, constants and codes of the buddy allocator.
package bma_pkg;

	localparam int MEM_UNITS_DEF   = 1024;
	localparam int ORDER_COUNT_DEF = 11;
	localparam int WORD_BITS       = 32;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_NOSPACE = 2'd1;
	localparam logic [1:0] RES_BAD     = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EX,
		ST_SPLIT_RD,
		ST_SPLIT_EX,
		ST_CHK_RD,
		ST_CHK_EX,
		ST_MRG_TST,
		ST_MRG_RD,
		ST_MRG_EX,
		ST_SET_RD,
		ST_SET_EX,
		ST_OUT
	} bma_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_SCAN_RD,
		CMD_SCAN_EX,
		CMD_SPLIT_RD,
		CMD_SPLIT_EX,
		CMD_CHK_RD,
		CMD_CHK_EX,
		CMD_MRG_RD,
		CMD_MRG_EX,
		CMD_SET_RD,
		CMD_SET_EX,
		CMD_OUT
	} bma_cmd_t;

	typedef struct packed {
		bma_cmd_t cmd;
	} bma_ctl_t;

	typedef struct packed {
		logic clear_done;
		logic load_bad;
		logic load_free;
		logic scan_hit;
		logic scan_last;
		logic at_top;
		logic at_k;
		logic node_set;
		logic out_free;
	} bma_sts_t;

endpackage

[rtl/buddy_memory_allocator.sv]
// Top level of the buddy allocator: sequencer and datapath.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | op, req_size, block_start
//  output  | out_valid | out_stall | status, granted_start
//
//  One item at a time. Each free-map access is a read state and an execute state,
//  which may write back, on one 32-bit memory port. An allocate scans map words
//  and then splits; a free checks each order, tries merge steps and marks the
//  block. The item is taken in the idle state and its result handed out last.
//  After reset a clearing pass over the free map runs with in_stall high.
//  A result waiting on out_stall does not block the next item from being taken.
module buddy_memory_allocator
	import bma_pkg::*;
#(
	parameter int MEM_UNITS   = MEM_UNITS_DEF,
	parameter int ORDER_COUNT = ORDER_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   op,
	input  logic [ORDER_COUNT-1:0] req_size,
	input  logic [ORDER_COUNT-2:0] block_start,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [ORDER_COUNT-2:0] granted_start
);

	bma_ctl_t ctl;
	bma_sts_t sts;

	bma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	bma_datapath #(
		.MEM_UNITS   (MEM_UNITS),
		.ORDER_COUNT (ORDER_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.op            (op),
		.req_size      (req_size),
		.block_start   (block_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.granted_start (granted_start)
	);

endmodule

[rtl/bma_ctrl.sv]
// Sequencer of the buddy allocator: walks search, split, check, merge and set steps.
module bma_ctrl
	import bma_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  bma_sts_t sts,
	output bma_ctl_t ctl
);

	bma_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.load_bad) state_d = ST_OUT;
					else if (sts.load_free) state_d = ST_CHK_RD;
					else state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_EX;
			ST_SCAN_EX: begin
				if (sts.scan_hit) state_d = sts.at_k ? ST_OUT : ST_SPLIT_RD;
				else if (sts.scan_last && sts.at_top) state_d = ST_OUT;
				else state_d = ST_SCAN_RD;
			end
			ST_SPLIT_RD: state_d = ST_SPLIT_EX;
			ST_SPLIT_EX: state_d = sts.at_k ? ST_OUT : ST_SPLIT_RD;
			ST_CHK_RD:   state_d = ST_CHK_EX;
			ST_CHK_EX: begin
				if (sts.node_set) state_d = ST_OUT;
				else if (sts.at_top) state_d = ST_MRG_TST;
				else state_d = ST_CHK_RD;
			end
			ST_MRG_TST: state_d = sts.at_top ? ST_SET_RD : ST_MRG_RD;
			ST_MRG_RD:  state_d = ST_MRG_EX;
			ST_MRG_EX:  state_d = sts.node_set ? ST_MRG_TST : ST_SET_RD;
			ST_SET_RD:  state_d = ST_SET_EX;
			ST_SET_EX:  state_d = ST_OUT;
			ST_OUT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctl.cmd  = CMD_NONE;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: ctl.cmd = CMD_CLEAR;
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) ctl.cmd = CMD_LOAD;
			end
			ST_SCAN_RD:  ctl.cmd = CMD_SCAN_RD;
			ST_SCAN_EX:  ctl.cmd = CMD_SCAN_EX;
			ST_SPLIT_RD: ctl.cmd = CMD_SPLIT_RD;
			ST_SPLIT_EX: ctl.cmd = CMD_SPLIT_EX;
			ST_CHK_RD:   ctl.cmd = CMD_CHK_RD;
			ST_CHK_EX:   ctl.cmd = CMD_CHK_EX;
			ST_MRG_TST:  ctl.cmd = CMD_NONE;
			ST_MRG_RD:   ctl.cmd = CMD_MRG_RD;
			ST_MRG_EX:   ctl.cmd = CMD_MRG_EX;
			ST_SET_RD:   ctl.cmd = CMD_SET_RD;
			ST_SET_EX:   ctl.cmd = CMD_SET_EX;
			ST_OUT:      ctl.cmd = CMD_OUT;
			default:     ctl.cmd = CMD_NONE;
		endcase
	end

endmodule

[rtl/bma_datapath.sv]
// Datapath of the buddy allocator: free-map memory, order and block registers, result register.
module bma_datapath
	import bma_pkg::*;
#(
	parameter int MEM_UNITS   = MEM_UNITS_DEF,
	parameter int ORDER_COUNT = ORDER_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bma_ctl_t               ctl,
	output bma_sts_t               sts,
	input  logic                   op,
	input  logic [ORDER_COUNT-1:0] req_size,
	input  logic [ORDER_COUNT-2:0] block_start,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [ORDER_COUNT-2:0] granted_start
);

	localparam int TOP    = ORDER_COUNT - 1;
	localparam int AW     = ORDER_COUNT - 1;
	localparam int SW     = ORDER_COUNT;
	localparam int OW     = $clog2(ORDER_COUNT);
	localparam int HW     = (ORDER_COUNT > 5) ? ORDER_COUNT : 6;
	localparam int WAW    = HW - 5;
	localparam int WDEPTH = 1 << WAW;

	logic [WORD_BITS-1:0] mem [WDEPTH];
	logic [WORD_BITS-1:0] rdata_q, wdata, hits, mask;
	logic                 we;

	logic          op_q, out_valid_q;
	logic [OW-1:0] k_q, j_q, nj, load_k;
	logic [AW-1:0] b_q, a_q, nb, found_b;
	logic [WAW-1:0] waddr_q, maddr;
	logic [1:0]    res_q, status_q;
	logic [AW-1:0] grant_q;
	logic [HW-1:0] node, base, last_idx, found_idx, idx;
	logic [HW-1:0] load_base, next_base;
	logic [4:0]    nbit, pos;
	logic          load_bad, out_free;
	logic [AW-1:0] align_mask;

	function automatic logic [HW-1:0] base_of(input logic [OW-1:0] j);
		base_of = HW'(1) << (OW'(TOP) - j);
	endfunction

	// order rounding of the requested size
	always_comb begin
		load_k = '0;
		for (int i = 0; i < TOP; i++) begin
			if ((SW'(1) << i) < req_size) load_k = OW'(i + 1);
		end
	end

	assign align_mask = (AW'(1) << load_k) - AW'(1);
	assign load_bad = (req_size == '0) || (req_size > SW'(MEM_UNITS)) ||
		(op && (({1'b0, block_start} >= (AW + 1)'(MEM_UNITS)) ||
		((block_start & align_mask) != '0)));

	always_comb begin
		nj = j_q;
		nb = b_q;
		case (ctl.cmd)
			CMD_SPLIT_RD: begin
				nj = j_q - OW'(1);
				nb = {b_q[AW-2:0], 1'b1};
			end
			CMD_SPLIT_EX: nb = b_q | AW'(1);
			CMD_CHK_RD, CMD_CHK_EX: nb = a_q;
			CMD_MRG_RD, CMD_MRG_EX: nb = b_q ^ AW'(1);
			default: nb = b_q;
		endcase
	end

	assign node  = base_of(nj) + HW'(nb);
	assign nbit  = node[4:0];
	assign maddr = (ctl.cmd == CMD_CLEAR || ctl.cmd == CMD_SCAN_RD || ctl.cmd == CMD_SCAN_EX) ?
		waddr_q : node[HW-1:5];

	// scan window of the current order
	assign base      = base_of(j_q);
	assign last_idx  = (base << 1) - HW'(1);
	assign load_base = base_of(load_k);
	assign next_base = base_of(j_q + OW'(1));

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			idx     = {waddr_q, 5'(i)};
			mask[i] = (idx >= base) && (idx <= last_idx);
		end
	end

	assign hits = rdata_q & mask;

	always_comb begin
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (hits[i]) pos = 5'(i);
		end
	end

	assign found_idx = {waddr_q, pos};
	assign found_b   = AW'(found_idx - base);

	always_comb begin
		we    = 1'b0;
		wdata = rdata_q;
		case (ctl.cmd)
			CMD_CLEAR: begin
				we    = 1'b1;
				wdata = (waddr_q == '0) ? WORD_BITS'(2) : '0;
			end
			CMD_SCAN_EX: begin
				we    = |hits;
				wdata = rdata_q & ~(WORD_BITS'(1) << pos);
			end
			CMD_SPLIT_EX, CMD_SET_EX: begin
				we    = 1'b1;
				wdata = rdata_q | (WORD_BITS'(1) << nbit);
			end
			CMD_MRG_EX: begin
				we    = rdata_q[nbit];
				wdata = rdata_q & ~(WORD_BITS'(1) << nbit);
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[maddr] <= wdata;
		rdata_q <= mem[maddr];
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waddr_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.cmd == CMD_OUT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (ctl.cmd)
				CMD_CLEAR: waddr_q <= waddr_q + WAW'(1);
				CMD_LOAD: waddr_q <= load_base[HW-1:5];
				CMD_SCAN_EX: begin
					if (!(|hits)) begin
						if (waddr_q == last_idx[HW-1:5]) begin
							if (j_q != OW'(TOP)) waddr_q <= next_base[HW-1:5];
						end else begin
							waddr_q <= waddr_q + WAW'(1);
						end
					end
				end
				default: waddr_q <= waddr_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LOAD: begin
				op_q  <= op;
				k_q   <= load_k;
				j_q   <= load_k;
				b_q   <= block_start >> load_k;
				a_q   <= block_start >> load_k;
				res_q <= load_bad ? RES_BAD : RES_OK;
			end
			CMD_SCAN_EX: begin
				if (|hits) b_q <= found_b;
				else if (waddr_q == last_idx[HW-1:5]) begin
					if (j_q == OW'(TOP)) res_q <= RES_NOSPACE;
					else j_q <= j_q + OW'(1);
				end
			end
			CMD_SPLIT_RD: begin
				j_q <= j_q - OW'(1);
				b_q <= {b_q[AW-2:0], 1'b0};
			end
			CMD_CHK_EX: begin
				if (rdata_q[nbit]) res_q <= RES_BAD;
				else if (j_q == OW'(TOP)) j_q <= k_q;
				else begin
					j_q <= j_q + OW'(1);
					a_q <= a_q >> 1;
				end
			end
			CMD_MRG_EX: begin
				if (rdata_q[nbit]) begin
					j_q <= j_q + OW'(1);
					b_q <= b_q >> 1;
				end
			end
			CMD_OUT: begin
				if (out_free) begin
					status_q <= res_q;
					grant_q  <= (!op_q && res_q == RES_OK) ? (b_q << k_q) : '0;
				end
			end
			default: res_q <= res_q;
		endcase
	end

	assign sts.clear_done = (waddr_q == WAW'(WDEPTH - 1));
	assign sts.load_bad   = load_bad;
	assign sts.load_free  = op;
	assign sts.scan_hit   = |hits;
	assign sts.scan_last  = (waddr_q == last_idx[HW-1:5]);
	assign sts.at_top     = (j_q == OW'(TOP));
	assign sts.at_k       = (j_q == k_q);
	assign sts.node_set   = rdata_q[nbit];
	assign sts.out_free   = out_free;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_start = grant_q;

endmodule

[rtl/bma_checker.sv]
// Port-level checks of the buddy allocator and their bind.
module bma_checker
	import bma_pkg::*;
#(
	parameter int ORDER_COUNT = ORDER_COUNT_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [1:0]             status,
	input logic [ORDER_COUNT-2:0] granted_start
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == RES_OK || status == RES_NOSPACE || status == RES_BAD))
		else $error("bad status code");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != RES_OK) |-> (granted_start == '0))
		else $error("nonzero start on failed item");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item taken while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(granted_start)))
		else $error("stalled result changed");

endmodule

bind buddy_memory_allocator bma_checker #(.ORDER_COUNT(ORDER_COUNT)) u_bma_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.granted_start (granted_start)
);

[tb/tb_top.sv]
// Self-checking testbench of the buddy allocator: table-driven directed items, then random traffic.
module tb_top;
	import bma_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNITS = 1024;
	localparam int ORDERS = 11;
	localparam int TOP = ORDERS - 1;
	localparam int DEPTH = (1 << ORDERS) - 1;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		logic op;
		logic [10:0] size;
		logic [9:0] start;
		logic chk;
		logic [1:0] st;
		logic [9:0] gs;
	} row_t;

	typedef struct {
		logic [1:0] st;
		logic [9:0] gs;
	} grant_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, op = 0, out_stall = 0;
	logic [10:0] req_size = 0;
	logic [9:0] block_start = 0;
	logic in_stall, out_valid;
	logic [1:0] status;
	logic [9:0] granted_start;

	bit free_bits[DEPTH];
	grant_t grants_due[$];
	logic [9:0] live_start[$];
	logic [10:0] live_size[$];
	int errors = 0, idle_cycles = 0;
	bit stim_done = 0;

	buddy_memory_allocator dut (.*);

	initial forever #1 clk = ~clk;

	function automatic int node_ix(int k, int b);
		int n;
		n = ((1 << (TOP - k)) - 1) + b;
		return n < DEPTH ? n : 0;
	endfunction

	function automatic int order_for(int size);
		int k;
		k = 0;
		while (k < TOP && (1 << k) < size) k++;
		return k;
	endfunction

	function automatic grant_t allocate_step(logic o, int size, int start);
		grant_t g;
		int k, j, b, a;
		bit hit;
		g.st = RES_BAD; g.gs = 10'd0;
		if (size == 0 || size > UNITS) return g;
		k = order_for(size);
		if (o == OP_ALLOC) begin
			hit = 0; b = 0;
			for (j = k; j <= TOP && !hit; j++) begin
				for (b = 0; b < (1 << (TOP - j)); b++)
					if (free_bits[node_ix(j, b)]) begin
						hit = 1;
						break;
					end
				if (hit) break;
			end
			if (!hit) begin
				g.st = RES_NOSPACE;
				return g;
			end
			free_bits[node_ix(j, b)] = 0;
			while (j > k) begin
				j--; b = b << 1;
				free_bits[node_ix(j, b + 1)] = 1;
			end
			g.st = RES_OK; g.gs = 10'(b << k);
			return g;
		end
		if (start >= UNITS || (start & ((1 << k) - 1)) != 0) return g;
		b = start >> k;
		a = b;
		for (j = k; j <= TOP; j++) begin
			if (free_bits[node_ix(j, a)]) return g;
			a = a >> 1;
		end
		while (k < TOP && free_bits[node_ix(k, b ^ 1)]) begin
			free_bits[node_ix(k, b ^ 1)] = 0;
			k++; b = b >> 1;
		end
		free_bits[node_ix(k, b)] = 1;
		g.st = RES_OK;
		return g;
	endfunction

	task automatic send(row_t r);
		grant_t g;
		int gap;
		gap = $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; op <= r.op; req_size <= r.size; block_start <= r.start;
		do @(posedge clk); while (in_stall);
		g = allocate_step(r.op, int'(r.size), int'(r.start));
		if (r.chk && (g.st != r.st || g.gs != r.gs)) begin
			errors++;
			if (errors <= 10)
				$display("table row mismatch: op %0d size %0d start %0d exp st %0d gs %0d got st %0d gs %0d",
					r.op, r.size, r.start, r.st, r.gs, g.st, g.gs);
		end
		if (r.op == OP_ALLOC && g.st == RES_OK) begin
			live_start.push_back(g.gs);
			live_size.push_back(r.size);
		end
		grants_due.push_back(g);
	endtask

	initial begin
		row_t tbl[$];
		row_t r;
		int i, n, pick;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		foreach (free_bits[i]) free_bits[i] = 0;
		free_bits[0] = 1;
		tbl = '{
			'{OP_ALLOC, 11'd0, 10'd0, 1'b1, RES_BAD, 10'd0},
			'{OP_ALLOC, 11'd1025, 10'd0, 1'b1, RES_BAD, 10'd0},
			'{OP_ALLOC, 11'h7FF, 10'h3FF, 1'b1, RES_BAD, 10'd0},
			'{OP_FREE, 11'd0, 10'd0, 1'b1, RES_BAD, 10'd0},
			'{OP_FREE, 11'd1024, 10'd0, 1'b1, RES_BAD, 10'd0},
			'{OP_ALLOC, 11'd1024, 10'd0, 1'b1, RES_OK, 10'd0},
			'{OP_ALLOC, 11'd1, 10'd0, 1'b1, RES_NOSPACE, 10'd0},
			'{OP_FREE, 11'd4, 10'd2, 1'b1, RES_BAD, 10'd0},
			'{OP_FREE, 11'd1024, 10'd0, 1'b1, RES_OK, 10'd0},
			'{OP_ALLOC, 11'd1, 10'h3FF, 1'b1, RES_OK, 10'd0},
			'{OP_ALLOC, 11'd3, 10'd0, 1'b0, RES_OK, 10'd0},
			'{OP_ALLOC, 11'd5, 10'd0, 1'b0, RES_OK, 10'd0},
			'{OP_ALLOC, 11'd512, 10'd0, 1'b0, RES_OK, 10'd0},
			'{OP_FREE, 11'd1, 10'd1, 1'b0, RES_OK, 10'd0},
			'{OP_FREE, 11'd1, 10'd0, 1'b0, RES_OK, 10'd0},
			'{OP_FREE, 11'd1, 10'd0, 1'b0, RES_OK, 10'd0},
			'{OP_FREE, 11'd2, 10'd0, 1'b0, RES_OK, 10'd0},
			'{OP_FREE, 11'd512, 10'd512, 1'b0, RES_OK, 10'd0},
			'{OP_FREE, 11'd1, 10'h3FF, 1'b0, RES_OK, 10'd0},
			'{OP_FREE, 11'd1024, 10'd0, 1'b0, RES_OK, 10'd0}
		};
		foreach (tbl[i]) send(tbl[i]);
		live_start.delete(); live_size.delete();
		for (n = 0; n < 950; n++) begin
			r.chk = 1'b0; r.st = RES_OK; r.gs = 10'd0;
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				r.op = OP_ALLOC;
				r.size = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1, 1024))
					: 11'($urandom_range(1, 40));
				r.start = 10'($urandom);
			end else if (pick < 88 && live_start.size() > 0) begin
				i = $urandom_range(0, live_start.size() - 1);
				r.op = OP_FREE; r.size = live_size[i]; r.start = live_start[i];
				live_start.delete(i); live_size.delete(i);
			end else begin
				r.op = 1'($urandom); r.size = 11'($urandom); r.start = 10'($urandom);
			end
			send(r);
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		grant_t g;
		int out_wait;
		out_wait = $urandom_range(0, 11);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (grants_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result status %0d gs %0d", status, granted_start);
				end else begin
					g = grants_due.pop_front();
					if (status !== g.st || granted_start !== g.gs) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp st %0d gs %0d got st %0d gs %0d",
								g.st, g.gs, status, granted_start);
					end
				end
				out_wait = $urandom_range(0, 11);
			end else if (out_valid && out_wait > 0) begin
				out_wait--;
			end
			out_stall <= (out_wait > 0);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (stim_done && grants_due.size() == 0) begin
				repeat (100) @(posedge clk);
				if (errors == 0 && grants_due.size() == 0) $display("DONE: 0 errors");
				else $display("DONE: errors detected");
				$finish;
			end
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end
endmodule
